@@ rtl/htb_pkg.sv @@
// Shared types and constants for the Huffman tree builder.
package htb_pkg;

  localparam int MAX_LEAVES  = 32;
  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = 6;
  localparam int LEAF_W      = 16;
  localparam int WEIGHT_W    = 21;
  localparam int COUNT_W     = 6;

  typedef enum logic [3:0] {
    S_LOAD,
    S_PREP,
    S_SCAN_A,
    S_DRAIN_A,
    S_PICK_A,
    S_SCAN_B,
    S_DRAIN_B,
    S_PICK_B,
    S_LINK_A,
    S_LINK_B,
    S_EMIT_RD,
    S_EMIT_WAIT
  } state_t;

  // Write request into the node table: a full row, or the parent link only.
  typedef struct packed {
    logic                row_en;
    logic                parent_en;
    logic [IDX_W-1:0]    addr;
    logic [WEIGHT_W-1:0] weight;
    logic [IDX_W-1:0]    parent;
    logic [IDX_W-1:0]    left;
    logic [IDX_W-1:0]    right;
  } table_wr_t;

  // One table row read back, tagged with its index.
  typedef struct packed {
    logic                valid;
    logic [IDX_W-1:0]    idx;
    logic [WEIGHT_W-1:0] weight;
    logic [IDX_W-1:0]    parent;
  } cand_t;

endpackage

@@ rtl/htb_node_table.sv @@
// Node table memories: weight, parent and child links, one write and one read port.
module htb_node_table
  import htb_pkg::*;
(
  input  logic                clk,
  input  table_wr_t           wr,
  input  logic [IDX_W-1:0]    rd_addr,
  output logic [WEIGHT_W-1:0] rd_weight,
  output logic [IDX_W-1:0]    rd_parent,
  output logic [IDX_W-1:0]    rd_left,
  output logic [IDX_W-1:0]    rd_right
);

  logic [WEIGHT_W-1:0] weight_mem [TABLE_DEPTH];
  logic [IDX_W-1:0]    parent_mem [TABLE_DEPTH];
  logic [IDX_W-1:0]    left_mem   [TABLE_DEPTH];
  logic [IDX_W-1:0]    right_mem  [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.row_en) begin
      weight_mem[wr.addr] <= wr.weight;
      left_mem[wr.addr]   <= wr.left;
      right_mem[wr.addr]  <= wr.right;
    end
    rd_weight <= weight_mem[rd_addr];
    rd_left   <= left_mem[rd_addr];
    rd_right  <= right_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr.row_en || wr.parent_en) begin
      parent_mem[wr.addr] <= wr.parent;
    end
    rd_parent <= parent_mem[rd_addr];
  end

endmodule

@@ rtl/htb_scan_unit.sv @@
// Running minimum over unparented rows; lowest index wins ties.
module htb_scan_unit
  import htb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                clear,
  input  cand_t               cand,
  input  logic [IDX_W-1:0]    skip,
  output logic [IDX_W-1:0]    best_idx,
  output logic [WEIGHT_W-1:0] best_weight
);

  logic found;
  logic take;

  // Strict less-than keeps the earlier row on equal weight.
  assign take = cand.valid && (cand.parent == '0) && (cand.idx != skip)
                && (!found || (cand.weight < best_weight));

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_idx    <= cand.idx;
      best_weight <= cand.weight;
    end
  end

endmodule

@@ rtl/huffman_tree_builder.sv @@
// Huffman tree builder top level: leaf loading, merge sequencer and row output.
//
// Usage:
//   Input channel (in_valid/in_ready, leaf_weight, last_weight): one leaf
//   weight per item. in_ready is high only while the block is loading. The
//   item with last_weight set starts construction over the stored leaves.
//   Up to MAX_LEAVES (32) leaves are kept; later weights are dropped and
//   the overflow bit is set on every row of that tree.
//   Output channel (out_valid/out_ready, node_* fields): rows 1 .. 2n-1 in
//   index order, leaves first, last_row set on the final row.
// Sequence:
//   Loading writes each accepted leaf straight into the table. After the
//   last leaf comes a prep state; then each merge for new row i makes two
//   passes of the shared compare unit over rows 1..i-1 through the table's
//   single read port (one row a cycle, then a drain state), a pick state
//   after each pass (the second also writes row i) and two link states
//   that write the parent links. Each row is then read in S_EMIT_RD and
//   shown in S_EMIT_WAIT until the receiver takes it.
// Reset clears the sequencer, leaf count and overflow flag; the table is
// not cleared, since every row is written before it is read. A stalled
// receiver simply holds the current row on the output ports.
module huffman_tree_builder
  import htb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [LEAF_W-1:0]   leaf_weight,
  input  logic                last_weight,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [IDX_W-1:0]    node_index,
  output logic [WEIGHT_W-1:0] node_weight,
  output logic [IDX_W-1:0]    parent_index,
  output logic [IDX_W-1:0]    left_index,
  output logic [IDX_W-1:0]    right_index,
  output logic                overflow,
  output logic                last_row
);

  state_t state, state_next;

  logic [COUNT_W-1:0]  leaf_count;   // leaves stored for this tree
  logic                dropped;      // weights dropped for this tree
  logic [IDX_W-1:0]    rows;         // rows in this tree, 2n-1
  logic [IDX_W-1:0]    node_i;       // row being built
  logic [IDX_W-1:0]    scan_k;       // row being read by the scan
  logic [IDX_W-1:0]    emit_j;       // row being shown
  logic [IDX_W-1:0]    a_idx;        // first child of the current merge
  logic [WEIGHT_W-1:0] a_weight;

  // Read pipeline tag: rows read last cycle feed the compare unit now.
  logic                pipe_valid;
  logic [IDX_W-1:0]    pipe_idx;

  table_wr_t           wr;
  logic [IDX_W-1:0]    rd_addr;
  logic [WEIGHT_W-1:0] rd_weight;
  logic [IDX_W-1:0]    rd_parent;
  logic [IDX_W-1:0]    rd_left;
  logic [IDX_W-1:0]    rd_right;

  cand_t               cand;
  logic                scan_clear;
  logic [IDX_W-1:0]    scan_skip;
  logic [IDX_W-1:0]    best_idx;
  logic [WEIGHT_W-1:0] best_weight;

  logic                in_accept;
  logic                has_room;
  logic                scan_end;
  logic [COUNT_W:0]    rows_wide;

  assign in_accept = in_valid && in_ready;
  assign has_room  = (leaf_count < COUNT_W'(MAX_LEAVES));
  assign scan_end  = (scan_k == node_i - IDX_W'(1));
  assign rows_wide = {leaf_count, 1'b0} - (COUNT_W+1)'(1);

  htb_node_table u_table (
    .clk       (clk),
    .wr        (wr),
    .rd_addr   (rd_addr),
    .rd_weight (rd_weight),
    .rd_parent (rd_parent),
    .rd_left   (rd_left),
    .rd_right  (rd_right)
  );

  assign cand.valid  = pipe_valid;
  assign cand.idx    = pipe_idx;
  assign cand.weight = rd_weight;
  assign cand.parent = rd_parent;

  htb_scan_unit u_scan (
    .clk         (clk),
    .rst         (rst),
    .clear       (scan_clear),
    .cand        (cand),
    .skip        (scan_skip),
    .best_idx    (best_idx),
    .best_weight (best_weight)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Next state, table read address and writes, scan clear and handshake outputs.
  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    scan_clear   = 1'b0;
    rd_addr      = scan_k;
    wr.row_en    = 1'b0;
    wr.parent_en = 1'b0;
    wr.addr      = scan_k;
    wr.weight    = '0;
    wr.parent    = '0;
    wr.left      = '0;
    wr.right     = '0;
    unique case (state)
      S_LOAD: begin
        in_ready  = 1'b1;
        wr.addr   = leaf_count + IDX_W'(1);
        wr.weight = WEIGHT_W'(leaf_weight);
        wr.row_en = in_valid && has_room;
        if (in_valid && last_weight) begin
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        // A single leaf is already the whole tree: go straight to output.
        scan_clear = 1'b1;
        state_next = (leaf_count == COUNT_W'(1)) ? S_EMIT_RD : S_SCAN_A;
      end
      S_SCAN_A: begin
        if (scan_end) begin
          state_next = S_DRAIN_A;
        end
      end
      S_DRAIN_A: begin
        state_next = S_PICK_A;
      end
      S_PICK_A: begin
        scan_clear = 1'b1;
        state_next = S_SCAN_B;
      end
      S_SCAN_B: begin
        if (scan_end) begin
          state_next = S_DRAIN_B;
        end
      end
      S_DRAIN_B: begin
        state_next = S_PICK_B;
      end
      S_PICK_B: begin
        // Write the new inner row with both children and their sum.
        wr.row_en  = 1'b1;
        wr.addr    = node_i;
        wr.weight  = a_weight + best_weight;
        wr.left    = a_idx;
        wr.right   = best_idx;
        state_next = S_LINK_A;
      end
      S_LINK_A: begin
        wr.parent_en = 1'b1;
        wr.addr      = a_idx;
        wr.parent    = node_i;
        state_next   = S_LINK_B;
      end
      S_LINK_B: begin
        wr.parent_en = 1'b1;
        wr.addr      = best_idx;
        wr.parent    = node_i;
        scan_clear   = 1'b1;
        state_next   = (node_i == rows) ? S_EMIT_RD : S_SCAN_A;
      end
      S_EMIT_RD: begin
        rd_addr    = emit_j;
        state_next = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        // Hold the read address so the shown row stays put while stalled.
        rd_addr   = emit_j;
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = (emit_j == rows) ? S_LOAD : S_EMIT_RD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  // Leaf count and overflow flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      leaf_count <= '0;
      dropped    <= 1'b0;
    end else if (in_accept) begin
      if (has_room) begin
        leaf_count <= leaf_count + COUNT_W'(1);
      end else begin
        dropped <= 1'b1;
      end
    end else if (state == S_EMIT_WAIT && out_ready && emit_j == rows) begin
      leaf_count <= '0;
      dropped    <= 1'b0;
    end
  end

  // Row counters and the first child of the current merge.
  always_ff @(posedge clk) begin
    case (state)
      S_PREP: begin
        rows   <= rows_wide[IDX_W-1:0];
        node_i <= leaf_count + IDX_W'(1);
        scan_k <= IDX_W'(1);
        emit_j <= IDX_W'(1);
      end
      S_SCAN_A, S_SCAN_B: begin
        scan_k <= scan_k + IDX_W'(1);
      end
      S_PICK_A: begin
        a_idx    <= best_idx;
        a_weight <= best_weight;
        scan_k   <= IDX_W'(1);
      end
      S_LINK_B: begin
        node_i <= node_i + IDX_W'(1);
        scan_k <= IDX_W'(1);
        emit_j <= IDX_W'(1);
      end
      S_EMIT_WAIT: begin
        if (out_ready) begin
          emit_j <= emit_j + IDX_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Skip the first child only during the second pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_skip <= '0;
    end else if (state == S_PICK_A) begin
      scan_skip <= best_idx;
    end else if (state == S_PREP || state == S_LINK_B) begin
      scan_skip <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= 1'b0;
    end else begin
      pipe_valid <= (state == S_SCAN_A) || (state == S_SCAN_B);
    end
  end

  always_ff @(posedge clk) begin
    pipe_idx <= scan_k;
  end

  assign node_index   = emit_j;
  assign node_weight  = rd_weight;
  assign parent_index = rd_parent;
  assign left_index   = rd_left;
  assign right_index  = rd_right;
  assign overflow     = dropped;
  assign last_row     = (emit_j == rows);

endmodule
